[rtl/hdu_pkg.sv]
// Package for the half-duplex 8N1 UART: beat types, constants and helpers.
`default_nettype none
package hdu_pkg;

    localparam int COUNTER_BITS = 16;
    localparam int PERIOD_BITS  = 16;

    localparam int unsigned TICK_HZ = 1000000;
    localparam int unsigned BAUD    = 9600;
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(TICK_HZ / BAUD);

    localparam logic [3:0] FRAME_BITS = 4'hA;
    localparam logic [9:0] FRAME_CHECK_MASK  = 10'h201;
    localparam logic [9:0] FRAME_CHECK_VALUE = 10'h200;
    localparam logic [8:0] STOP_MASK = 9'h100;

    localparam logic [63:0] CNT_MAX = (64'd1 << COUNTER_BITS) - 64'd1;

    typedef struct packed {
        logic       rx_line;
        logic       send_request;
        logic [7:0] send_byte;
        logic       take_request;
    } uart_in_t;

    typedef struct packed {
        logic       tx_line;
        logic       send_accepted;
        logic       send_busy;
        logic       receiving;
        logic       byte_ready;
        logic [7:0] received_byte;
    } uart_out_t;

    // counter reload: zero times as one tick, oversize saturates
    function automatic logic [COUNTER_BITS-1:0] load_value(input logic [PERIOD_BITS-1:0] p);
        logic [63:0] v;
        v = 64'(p);
        if (v > CNT_MAX)
        begin
            v = CNT_MAX;
        end
        if (v == 64'd0)
        begin
            v = 64'd1;
        end
        return v[COUNTER_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

[rtl/hdu_core.sv]
// UART state and per-tick update; computes one result beat per accepted tick.
`default_nettype none
module hdu_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          fire,
    input  wire hdu_pkg::uart_in_t             item,
    input  wire logic [hdu_pkg::PERIOD_BITS-1:0] bit_period,
    output hdu_pkg::uart_out_t                 result
);

    logic [hdu_pkg::COUNTER_BITS-1:0] tick_counter_reg, tick_counter_next;
    logic [9:0] tx_shift_reg, tx_shift_next;
    logic [3:0] tx_bits_left_reg, tx_bits_left_next;
    logic       tx_active_reg, tx_active_next;
    logic       tx_level_reg, tx_level_next;
    logic [9:0] rx_shift_reg, rx_shift_next;
    logic [3:0] rx_bits_left_reg, rx_bits_left_next;
    logic       rx_active_reg, rx_active_next;
    logic       rx_previous_reg, rx_previous_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic       held_valid_reg, held_valid_next;

    logic [hdu_pkg::COUNTER_BITS-1:0] cnt_dec;
    logic       tick_event;
    logic       accepted;
    logic [9:0] rx_shifted;
    logic [3:0] tx_left_dec;
    logic [3:0] rx_left_dec;

    always_comb
    begin
        cnt_dec     = (tick_counter_reg != '0) ?
                      tick_counter_reg - {{(hdu_pkg::COUNTER_BITS-1){1'b0}}, 1'b1} : '0;
        tick_event  = (cnt_dec == '0);
        rx_shifted  = {item.rx_line, rx_shift_reg[9:1]};
        tx_left_dec = (tx_bits_left_reg != 4'd0) ? tx_bits_left_reg - 4'd1 : 4'd0;
        rx_left_dec = (rx_bits_left_reg != 4'd0) ? rx_bits_left_reg - 4'd1 : 4'd0;

        tick_counter_next = tick_counter_reg;
        tx_shift_next     = tx_shift_reg;
        tx_bits_left_next = tx_bits_left_reg;
        tx_active_next    = tx_active_reg;
        tx_level_next     = tx_level_reg;
        rx_shift_next     = rx_shift_reg;
        rx_bits_left_next = rx_bits_left_reg;
        rx_active_next    = rx_active_reg;
        rx_previous_next  = item.rx_line;
        held_byte_next    = held_byte_reg;
        held_valid_next   = held_valid_reg && !item.take_request;
        accepted          = 1'b0;

        if (tx_active_reg)
        begin
            tick_counter_next = tick_event ? hdu_pkg::load_value(bit_period) : cnt_dec;
            if (tick_event)
            begin
                tx_level_next     = tx_shift_reg[0];
                tx_shift_next     = {1'b0, tx_shift_reg[9:1]};
                tx_bits_left_next = tx_left_dec;
                tx_active_next    = (tx_left_dec != 4'd0);
            end
        end
        else if (rx_active_reg)
        begin
            tick_counter_next = tick_event ? hdu_pkg::load_value(bit_period) : cnt_dec;
            if (tick_event)
            begin
                rx_shift_next     = rx_shifted;
                rx_bits_left_next = rx_left_dec;
                if (rx_left_dec == 4'd0)
                begin
                    rx_active_next = 1'b0;
                    if ((rx_shifted & hdu_pkg::FRAME_CHECK_MASK) == hdu_pkg::FRAME_CHECK_VALUE)
                    begin
                        held_byte_next  = rx_shifted[8:1];
                        held_valid_next = 1'b1;
                    end
                end
            end
        end
        else if (item.send_request)
        begin
            accepted          = 1'b1;
            tx_shift_next     = {hdu_pkg::STOP_MASK | {1'b0, item.send_byte}, 1'b0};
            tx_bits_left_next = hdu_pkg::FRAME_BITS;
            tx_active_next    = 1'b1;
            tx_level_next     = 1'b1;
            tick_counter_next = hdu_pkg::load_value(bit_period);
        end
        else if (rx_previous_reg && !item.rx_line)
        begin
            rx_active_next    = 1'b1;
            rx_shift_next     = '0;
            rx_bits_left_next = hdu_pkg::FRAME_BITS;
            tick_counter_next = hdu_pkg::load_value({1'b0, bit_period[hdu_pkg::PERIOD_BITS-1:1]});
        end

        result.tx_line       = tx_level_next;
        result.send_accepted = accepted;
        result.send_busy     = tx_active_next;
        result.receiving     = rx_active_next;
        result.byte_ready    = held_valid_next;
        result.received_byte = held_byte_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_counter_reg <= '0;
            tx_shift_reg     <= '1;
            tx_bits_left_reg <= '0;
            tx_active_reg    <= 1'b0;
            tx_level_reg     <= 1'b1;
            rx_shift_reg     <= '0;
            rx_bits_left_reg <= '0;
            rx_active_reg    <= 1'b0;
            rx_previous_reg  <= 1'b1;
            held_byte_reg    <= '0;
            held_valid_reg   <= 1'b0;
        end
        else if (fire)
        begin
            tick_counter_reg <= tick_counter_next;
            tx_shift_reg     <= tx_shift_next;
            tx_bits_left_reg <= tx_bits_left_next;
            tx_active_reg    <= tx_active_next;
            tx_level_reg     <= tx_level_next;
            rx_shift_reg     <= rx_shift_next;
            rx_bits_left_reg <= rx_bits_left_next;
            rx_active_reg    <= rx_active_next;
            rx_previous_reg  <= rx_previous_next;
            held_byte_reg    <= held_byte_next;
            held_valid_reg   <= held_valid_next;
        end
    end

endmodule
`default_nettype wire

[rtl/hdu_skid.sv]
// Result register with a skid stage so the input side can still take a beat under a stall.
`default_nettype none
module hdu_skid (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire hdu_pkg::uart_out_t push_data,
    output logic                    full,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output hdu_pkg::uart_out_t      out_data
);

    logic               main_valid_reg, main_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    hdu_pkg::uart_out_t main_data_reg, main_data_next;
    hdu_pkg::uart_out_t skid_data_reg, skid_data_next;
    logic               pop;

    always_comb
    begin
        pop             = main_valid_reg && !out_stall;
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_data_next  = push_data;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_data_next  = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

endmodule
`default_nettype wire

[rtl/half_duplex_uart_8n1.sv]
// Top level of the half-duplex 8N1 UART.
// Each input beat is one timer tick: rx_line level, a send request with its byte,
// and a take request. Every accepted beat yields exactly one output beat holding
// tx_line, send_accepted, send_busy, receiving, byte_ready and received_byte as
// they stand after that tick.
// Throughput: one beat per cycle while in_stall is low; the state update and the
// result are computed in the accepting cycle and captured in the output buffer.
// A two-entry output buffer (result register plus skid) lets a new beat be
// accepted while a result waits; in_stall rises only once both are full.
// Config: cfg_data is bit_period (ticks per serial bit), written whenever
// cfg_valid is high; cfg_ready is always high. Write only while idle.
// Reset: both lines idle high, no activity, byte_ready low, received_byte 0,
// bit_period 104, output buffer empty.
`default_nettype none
module half_duplex_uart_8n1 (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire hdu_pkg::uart_in_t               in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output hdu_pkg::uart_out_t                   out_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [hdu_pkg::PERIOD_BITS-1:0] cfg_data
);

    logic [hdu_pkg::PERIOD_BITS-1:0] bit_period_reg;
    logic                            in_fire;
    logic                            buf_full;
    hdu_pkg::uart_out_t              result;

    assign cfg_ready = 1'b1;
    assign in_stall  = buf_full;
    assign in_fire   = in_valid && !buf_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg <= hdu_pkg::PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            bit_period_reg <= cfg_data;
        end
    end

    hdu_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (in_fire),
        .item       (in_data),
        .bit_period (bit_period_reg),
        .result     (result)
    );

    hdu_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_fire),
        .push_data (result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

[bench/half_duplex_uart_8n1_checker.sv]
// Tick-level predictor and result checker for the half-duplex 8N1 UART.
`timescale 1ns / 1ps
module half_duplex_uart_8n1_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  hdu_pkg::uart_in_t               in_data,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  hdu_pkg::uart_out_t              out_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [hdu_pkg::PERIOD_BITS-1:0] cfg_data,
    output int unsigned                     pending,
    output int unsigned                     mismatches
);

    localparam int CW = hdu_pkg::COUNTER_BITS;
    localparam longint unsigned COUNT_TOP = (64'd1 << CW) - 64'd1;

    logic [hdu_pkg::PERIOD_BITS-1:0] period_q;
    logic [CW-1:0]          tick_cnt;
    logic [9:0]             tx_sr;
    logic [3:0]             tx_left;
    logic                   tx_on;
    logic                   tx_lvl;
    logic [9:0]             rx_sr;
    logic [3:0]             rx_left;
    logic                   rx_on;
    logic                   rx_prev;
    logic [7:0]             held;
    logic                   held_ok;

    hdu_pkg::uart_out_t expected_q[$];
    hdu_pkg::uart_out_t want;
    hdu_pkg::uart_out_t line_state;
    int unsigned fail_cnt = 0;
    int unsigned pending_q = 0;

    assign pending    = pending_q;
    assign mismatches = fail_cnt;

    task automatic report(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_cnt++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] exp_val);
        if (got !== exp_val)
        begin
            report($sformatf("%s mismatch: got %0h, expected %0h", name, got, exp_val));
        end
    endtask

    function automatic logic [CW-1:0] reload_count(input logic [hdu_pkg::PERIOD_BITS-1:0] p);
        longint unsigned v;
        v = 64'(p);
        if (v > COUNT_TOP)
        begin
            v = COUNT_TOP;
        end
        if (v == 0)
        begin
            v = 1;
        end
        return CW'(v);
    endfunction

    // one tick of the shared bit timer; true on reload
    function automatic bit bit_time_elapsed();
        if (tick_cnt != '0)
        begin
            tick_cnt = tick_cnt - CW'(1);
        end
        if (tick_cnt == '0)
        begin
            tick_cnt = reload_count(period_q);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic clear_uart();
        period_q = hdu_pkg::PERIOD_RESET;
        tick_cnt = '0;
        tx_sr    = '1;
        tx_left  = '0;
        tx_on    = 1'b0;
        tx_lvl   = 1'b1;
        rx_sr    = '0;
        rx_left  = '0;
        rx_on    = 1'b0;
        rx_prev  = 1'b1;
        held     = '0;
        held_ok  = 1'b0;
    endtask

    task automatic predict_tick(input hdu_pkg::uart_in_t t, output hdu_pkg::uart_out_t r);
        logic idle_now;
        logic taken;
        idle_now = !tx_on && !rx_on;
        taken    = 1'b0;
        if (t.take_request)
        begin
            held_ok = 1'b0;
        end
        if (tx_on)
        begin
            if (bit_time_elapsed())
            begin
                tx_lvl = tx_sr[0];
                tx_sr  = {1'b0, tx_sr[9:1]};
                if (tx_left != 0)
                begin
                    tx_left--;
                end
                if (tx_left == 0)
                begin
                    tx_on = 1'b0;
                end
            end
        end
        else if (rx_on)
        begin
            if (bit_time_elapsed())
            begin
                rx_sr = {t.rx_line, rx_sr[9:1]};
                if (rx_left != 0)
                begin
                    rx_left--;
                end
                if (rx_left == 0)
                begin
                    rx_on = 1'b0;
                    if (rx_sr[0] == 1'b0 && rx_sr[9] == 1'b1)
                    begin
                        held    = rx_sr[8:1];
                        held_ok = 1'b1;
                    end
                end
            end
        end
        else if (idle_now)
        begin
            if (t.send_request)
            begin
                taken    = 1'b1;
                tx_sr    = {1'b1, t.send_byte, 1'b0};
                tx_left  = 4'd10;
                tx_on    = 1'b1;
                tx_lvl   = 1'b1;
                tick_cnt = reload_count(period_q);
            end
            else if (rx_prev && !t.rx_line)
            begin
                rx_on    = 1'b1;
                rx_sr    = '0;
                rx_left  = 4'd10;
                tick_cnt = reload_count(period_q >> 1);
            end
        end
        rx_prev = t.rx_line;
        r.tx_line       = tx_lvl;
        r.send_accepted = taken;
        r.send_busy     = tx_on;
        r.receiving     = rx_on;
        r.byte_ready    = held_ok;
        r.received_byte = held;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_uart();
            expected_q.delete();
            pending_q <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    report("result beat with no expectation pending");
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("tx_line", 8'(out_data.tx_line), 8'(want.tx_line));
                    check_field("send_accepted", 8'(out_data.send_accepted),
                                8'(want.send_accepted));
                    check_field("send_busy", 8'(out_data.send_busy), 8'(want.send_busy));
                    check_field("receiving", 8'(out_data.receiving), 8'(want.receiving));
                    check_field("byte_ready", 8'(out_data.byte_ready), 8'(want.byte_ready));
                    check_field("received_byte", out_data.received_byte, want.received_byte);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                period_q = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                predict_tick(in_data, line_state);
                expected_q.push_back(line_state);
            end
            pending_q <= expected_q.size();
        end
    end

endmodule

[bench/half_duplex_uart_8n1_tb.sv]
// Testbench top for the half-duplex 8N1 UART: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module half_duplex_uart_8n1_tb;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned RANDOM_TICKS = 600;
    localparam int          PW           = hdu_pkg::PERIOD_BITS;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    hdu_pkg::uart_in_t      in_data = '1;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    hdu_pkg::uart_out_t     out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [PW-1:0]          cfg_data = '0;

    int unsigned pending;
    int unsigned mismatches;

    int unsigned            sender_idle_pct = 0;
    int unsigned            stall_pct = 0;
    int unsigned            ticks_sent = 0;
    int unsigned            cycle_cnt = 0;
    logic [PW-1:0]          cur_period = hdu_pkg::PERIOD_RESET;
    logic                   line_levels[$];

    half_duplex_uart_8n1 i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    half_duplex_uart_8n1_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .mismatches (mismatches)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic hdu_pkg::uart_in_t mk(input logic rx, input logic snd,
                                             input logic [7:0] b, input logic tk);
        hdu_pkg::uart_in_t t;
        t.rx_line      = rx;
        t.send_request = snd;
        t.send_byte    = b;
        t.take_request = tk;
        return t;
    endfunction

    function automatic hdu_pkg::uart_in_t rand_tick();
        hdu_pkg::uart_in_t t;
        t = hdu_pkg::uart_in_t'($urandom);
        return t;
    endfunction

    function automatic int bit_ticks();
        return (cur_period == 0) ? 1 : int'(cur_period);
    endfunction

    // one beat = one timer tick
    task automatic push_tick(input hdu_pkg::uart_in_t t);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        ticks_sent++;
    endtask

    // stop sending until every expected result beat is back
    task automatic drain();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
    endtask

    task automatic write_period(input logic [PW-1:0] p);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= p;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        cur_period = p;
    endtask

    // serial frame at the current bit period: start, 8 data LSB first, stop, idle gap
    task automatic queue_frame(input logic [7:0] data, input bit bad_start, input bit bad_stop);
        int   w;
        logic lvl;
        w = bit_ticks();
        for (int k = 0; k < 10; k++)
        begin
            if (k == 0)
            begin
                lvl = 1'b0;
            end
            else if (k == 9)
            begin
                lvl = !bad_stop;
            end
            else
            begin
                lvl = data[k-1];
            end
            for (int j = 0; j < w; j++)
            begin
                line_levels.push_back((k == 0 && bad_start && j > 0) ? 1'b1 : lvl);
            end
        end
        repeat ($urandom_range(1, 2 * w))
        begin
            line_levels.push_back(1'b1);
        end
    endtask

    task automatic play_line(input int take_at, input int unsigned send_pct,
                             input int unsigned take_pct);
        int                i;
        hdu_pkg::uart_in_t t;
        i = 0;
        while (line_levels.size() != 0)
        begin
            t.rx_line      = line_levels.pop_front();
            t.send_request = ($urandom_range(99) < send_pct);
            t.send_byte    = 8'($urandom);
            t.take_request = (i == take_at) || ($urandom_range(99) < take_pct);
            push_tick(t);
            i++;
        end
    endtask

    task automatic run_random(input int unsigned n);
        int unsigned first;
        int unsigned roll;
        int          w;
        first = ticks_sent;
        while (ticks_sent - first < n)
        begin
            w    = bit_ticks();
            roll = $urandom_range(99);
            if (roll < 60)
            begin
                queue_frame(8'($urandom), $urandom_range(99) < 8, $urandom_range(99) < 8);
                play_line(-1, 2, 10);
            end
            else if (roll < 85)
            begin
                push_tick(mk(1'b1, 1'b1, 8'($urandom), $urandom_range(99) < 10));
                repeat (10 * w)
                begin
                    push_tick(mk($urandom_range(99) >= 15, $urandom_range(99) < 10,
                                 8'($urandom), $urandom_range(99) < 10));
                end
                push_tick(mk(1'b1, 1'b0, 8'($urandom), 1'b0));
            end
            else
            begin
                repeat ($urandom_range(2, 12))
                begin
                    push_tick(rand_tick());
                end
                repeat (10 * w + 2)
                begin
                    push_tick(mk(1'b1, 1'b0, 8'($urandom), $urandom_range(99) < 10));
                end
            end
        end
    endtask

    task automatic random_phase(input int unsigned idle_pct, input int unsigned hold_pct);
        sender_idle_pct = idle_pct;
        stall_pct       = hold_pct;
        repeat (2)
        begin
            write_period(PW'($urandom_range(2, 9)));
            run_random(RANDOM_TICKS / 6);
        end
    endtask

    initial
    begin
        sender_idle_pct = 18;
        stall_pct       = 76;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // take with nothing held, at the reset period
        push_tick(mk(1'b1, 1'b0, 8'h00, 1'b1));

        // zero period: send beats a simultaneous falling edge, then busy ignores sends and edges
        write_period(16'd0);
        push_tick(mk(1'b0, 1'b1, 8'hFF, 1'b0));
        for (int i = 0; i < 10; i++)
        begin
            push_tick(mk(i[0], (i % 3) == 0, 8'h00, 1'b0));
        end
        push_tick(mk(1'b1, 1'b0, 8'h00, 1'b0));

        // period one: first sample lands a tick late
        write_period(16'd1);
        queue_frame(8'h3C, 1'b0, 1'b0);
        play_line(-1, 0, 0);

        // good frame with a take on the stop sample, then bad stop, take, bad start
        write_period(16'd2);
        queue_frame(8'hFF, 1'b0, 1'b0);
        play_line(19, 0, 0);
        queue_frame(8'h00, 1'b0, 1'b1);
        play_line(-1, 0, 0);
        push_tick(mk(1'b1, 1'b0, 8'h00, 1'b1));
        queue_frame(8'hA5, 1'b1, 1'b0);
        play_line(-1, 0, 0);

        random_phase(18, 76);
        random_phase(76, 18);
        random_phase(0, 0);

        // long period, shortened again mid-frame
        write_period(16'd200);
        push_tick(mk(1'b1, 1'b1, 8'hFF, 1'b0));
        repeat (20)
        begin
            push_tick(rand_tick());
        end
        write_period(16'd2);
        repeat (210)
        begin
            push_tick(rand_tick());
        end
        repeat (40)
        begin
            push_tick(mk(1'b1, 1'b0, 8'h00, 1'b0));
        end
        queue_frame(8'h81, 1'b0, 1'b0);
        play_line(-1, 0, 0);

        drain();
        repeat (4) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
